// ----- hw/rtl/cfalu_pkg.sv -----
`timescale 1ns / 1ps
package cfalu_pkg;

  localparam int DATA_W = 64;

  localparam logic [4:0] OP_CVTL = 5'd0;
  localparam logic [4:0] OP_ADD  = 5'd1;
  localparam logic [4:0] OP_SUB  = 5'd2;
  localparam logic [4:0] OP_MPY  = 5'd3;
  localparam logic [4:0] OP_DIV  = 5'd4;
  localparam logic [4:0] OP_MOD  = 5'd5;
  localparam logic [4:0] OP_AND  = 5'd6;
  localparam logic [4:0] OP_IOR  = 5'd7;
  localparam logic [4:0] OP_XOR  = 5'd8;
  localparam logic [4:0] OP_SHL  = 5'd9;
  localparam logic [4:0] OP_SHR  = 5'd10;
  localparam logic [4:0] OP_NOT  = 5'd11;
  localparam logic [4:0] OP_LNOT = 5'd12;
  localparam logic [4:0] OP_SQR  = 5'd13;
  localparam logic [4:0] OP_NEG  = 5'd14;
  localparam logic [4:0] OP_ABS  = 5'd15;
  localparam logic [4:0] OP_ODD  = 5'd16;
  localparam logic [4:0] OP_GEQ  = 5'd17;
  localparam logic [4:0] OP_GRT  = 5'd18;
  localparam logic [4:0] OP_LEQ  = 5'd19;
  localparam logic [4:0] OP_LES  = 5'd20;
  localparam logic [4:0] OP_EQU  = 5'd21;
  localparam logic [4:0] OP_NEQ  = 5'd22;
  localparam logic [4:0] OP_MIN  = 5'd23;
  localparam logic [4:0] OP_MAX  = 5'd24;
  localparam logic [4:0] OP_DUP  = 5'd25;

  localparam logic [63:0] NEG_2P31 = 64'hFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic [4:0]         command;
    logic signed [63:0] op_a;
    logic signed [63:0] op_b;
    logic               signed_mode;
    logic               narrow_32;
    logic               trap_overflow;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic signed [63:0] value;
    logic               div_by_zero;
  } rsp_t;

  typedef struct packed {
    logic        ok;
    logic        dbz;
    logic        is_mul;
    logic        is_div;
    logic        is_mod;
    logic        neg;
    logic [63:0] value;
    logic [63:0] p0;
    logic [31:0] p1;
    logic [31:0] p2;
  } s1_t;

  typedef struct packed {
    logic        ok;
    logic        dbz;
    logic        is_div;
    logic        is_mod;
    logic        neg;
    logic [63:0] value;
  } side_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] den;
  } div_t;

endpackage

// ----- hw/rtl/constant_fold_alu_unit.sv -----
`timescale 1ns / 1ps
// constant folding alu, 64-bit integer operations
// input channel: a beat is taken at a rising edge with start high and busy low;
//   busy is always low, so a new beat can be issued every cycle
// output channel: done is high for exactly one cycle with rsp valid; the
//   receiver cannot hold results off and none is needed, results leave in order
// flow: every command passes through the same stages; throughput one beat per cycle
// pipeline: one stage of decode and simple ops with 32x32 partial products,
//   one stage summing the product, 64 stages of restoring division with one
//   quotient bit each, one output stage
// reset: synchronous rst clears all valid bits; beats in flight are dropped
module constant_fold_alu_unit
  import cfalu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int STEPS = DATA_W;

  logic  v1, v2, vo;
  s1_t   s1, s1_next;
  side_t s2, s2_next;
  div_t  d1, d1_next, d2;
  logic  vd [STEPS];
  side_t sd [STEPS];
  div_t  dd [STEPS];

  assign busy = 1'b0;

  function automatic div_t div_step(div_t x);
    div_t        y;
    logic [64:0] r2;
    logic [64:0] diff;
    r2   = {x.rem, x.quo[63]};
    diff = r2 - {1'b0, x.den};
    y.den = x.den;
    if (!diff[64]) begin
      y.rem = diff[63:0];
      y.quo = {x.quo[62:0], 1'b1};
    end else begin
      y.rem = r2[63:0];
      y.quo = {x.quo[62:0], 1'b0};
    end
    return y;
  endfunction

  always_comb begin
    logic [63:0] a, b, m, sh, ma, mb, bb;
    logic        sg, tr, ltab, ltba, na, nb;
    logic [64:0] sum;
    logic [31:0] n32;
    a  = req.op_a;
    b  = req.op_b;
    sg = req.signed_mode;
    tr = req.trap_overflow;
    ltab = sg ? ($signed(a) < $signed(b)) : (a < b);
    ltba = sg ? ($signed(b) < $signed(a)) : (b < a);
    na = a[63];
    nb = b[63];
    ma = (sg && na) ? -a : a;
    mb = (sg && nb) ? -b : b;
    bb = (req.command == OP_SQR) ? a : b;
    m  = '0;
    sh = '0;
    sum = '0;
    n32 = '0;
    s1_next = '0;
    s1_next.ok = 1'b1;
    s1_next.p0 = a[31:0] * bb[31:0];
    s1_next.p1 = a[31:0] * bb[63:32];
    s1_next.p2 = a[63:32] * bb[31:0];
    d1_next.rem = '0;
    d1_next.quo = sg ? ma : a;
    d1_next.den = sg ? mb : b;
    case (req.command)
      OP_CVTL: begin
        if (tr) s1_next.ok = 1'b0;
        else if (b == 64'd0) s1_next.value = '0;
        else if (b >= 64'(DATA_W)) s1_next.value = a;
        else begin
          m = (64'd1 << b[5:0]) - 64'd1;
          s1_next.value = a & m;
          if (sg && a[b[5:0] - 6'd1]) s1_next.value = s1_next.value | ~m;
        end
      end
      OP_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        s1_next.value = sum[63:0];
        if (tr && (sg ? (na == nb && sum[63] != na) : sum[64])) s1_next.ok = 1'b0;
      end
      OP_SUB: begin
        sum = {1'b0, a} - {1'b0, b};
        s1_next.value = sum[63:0];
        if (tr && (sg ? (na != nb && sum[63] != na) : sum[64])) s1_next.ok = 1'b0;
      end
      OP_MPY, OP_SQR: begin
        if (tr) s1_next.ok = 1'b0;
        s1_next.is_mul = 1'b1;
      end
      OP_DIV, OP_MOD: begin
        s1_next.is_div = 1'b1;
        s1_next.is_mod = (req.command == OP_MOD);
        s1_next.neg = sg && ((req.command == OP_MOD) ? na : (na ^ nb));
        if (b == 64'd0) begin
          s1_next.ok  = 1'b0;
          s1_next.dbz = 1'b1;
        end else if (req.command == OP_DIV && sg && tr && a == NEG_2P31 && b == '1) begin
          s1_next.ok = 1'b0;
        end
      end
      OP_AND: s1_next.value = a & b;
      OP_IOR: s1_next.value = a | b;
      OP_XOR: s1_next.value = a ^ b;
      OP_SHL: begin
        if (req.narrow_32) begin
          n32 = a[31:0] << b[4:0];
          s1_next.value = {{32{n32[31]}}, n32};
        end else s1_next.value = a << b[5:0];
      end
      OP_SHR: begin
        if (req.narrow_32) begin
          sh = sg ? {{32{a[31]}}, a[31:0]} : {32'd0, a[31:0]};
          s1_next.value = sg ? 64'($signed(sh) >>> b[4:0]) : (sh >> b[4:0]);
        end else begin
          s1_next.value = sg ? 64'($signed(a) >>> b[5:0]) : (a >> b[5:0]);
        end
      end
      OP_NOT:  s1_next.value = ~a;
      OP_LNOT: s1_next.value = {63'd0, a == 64'd0};
      OP_NEG: begin
        if (tr && sg && a == NEG_2P31) s1_next.ok = 1'b0;
        s1_next.value = -a;
      end
      OP_ABS: begin
        if (sg && a == NEG_2P31) begin
          if (tr) s1_next.ok = 1'b0;
          s1_next.value = a;
        end else s1_next.value = (sg && na) ? -a : a;
      end
      OP_ODD: s1_next.value = {63'd0, a[0]};
      OP_GEQ: s1_next.value = {63'd0, !ltab};
      OP_GRT: s1_next.value = {63'd0, ltba};
      OP_LEQ: s1_next.value = {63'd0, !ltba};
      OP_LES: s1_next.value = {63'd0, ltab};
      OP_EQU: s1_next.value = {63'd0, a == b};
      OP_NEQ: s1_next.value = {63'd0, a != b};
      OP_MIN: s1_next.value = ltba ? b : a;
      OP_MAX: s1_next.value = ltab ? b : a;
      OP_DUP: s1_next.value = a;
      default: s1_next.ok = 1'b0;
    endcase
  end

  always_comb begin
    s2_next.ok     = s1.ok;
    s2_next.dbz    = s1.dbz;
    s2_next.is_div = s1.is_div;
    s2_next.is_mod = s1.is_mod;
    s2_next.neg    = s1.neg;
    s2_next.value  = s1.is_mul ? (s1.p0 + {s1.p1 + s1.p2, 32'd0}) : s1.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vo <= 1'b0;
      for (int i = 0; i < STEPS; i++) vd[i] <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      vd[0] <= v2;
      for (int i = 1; i < STEPS; i++) vd[i] <= vd[i-1];
      vo <= vd[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [63:0] r;
    s1 <= s1_next;
    d1 <= d1_next;
    s2 <= s2_next;
    d2 <= d1;
    sd[0] <= s2;
    dd[0] <= div_step(d2);
    for (int i = 1; i < STEPS; i++) begin
      sd[i] <= sd[i-1];
      dd[i] <= div_step(dd[i-1]);
    end
    r = sd[STEPS-1].is_mod ? dd[STEPS-1].rem : dd[STEPS-1].quo;
    if (sd[STEPS-1].neg) r = -r;
    if (!sd[STEPS-1].is_div) r = sd[STEPS-1].value;
    rsp.ok          <= sd[STEPS-1].ok;
    rsp.div_by_zero <= sd[STEPS-1].dbz;
    rsp.value       <= sd[STEPS-1].ok ? r : 64'd0;
  end

  assign done = vo;

endmodule

// ----- tb/sv/constant_fold_alu_unit_tb.sv -----
`timescale 1ns / 1ps
module constant_fold_alu_unit_tb;
  import cfalu_pkg::*;

  localparam int LATENCY = 67;
  localparam int RANDOM_BEATS = 1800;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  rsp_t rsp;

  req_t cmd_queue[$];
  rsp_t fold_queue[$];
  int mismatches = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  constant_fold_alu_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .rsp(rsp)
  );

  always #2 clk = ~clk;

  function automatic logic signed_lt(logic [63:0] x, logic [63:0] y, logic sgn);
    if (sgn) return $signed(x) < $signed(y);
    return x < y;
  endfunction

  function automatic logic [63:0] sext_low32(logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  function automatic rsp_t fold_result(req_t r);
    rsp_t o;
    logic [63:0] a, b, v, ma, mb, q, m;
    logic okv, dbz, sgn, trp, na, nb;
    logic [4:0] sh;
    a = r.op_a; b = r.op_b; sgn = r.signed_mode; trp = r.trap_overflow;
    okv = 1'b1; dbz = 1'b0; v = '0;
    case (r.command)
      OP_CVTL: begin
        if (trp) okv = 1'b0;
        else if (b == 0) v = '0;
        else if (b >= 64) v = a;
        else begin
          m = (64'd1 << b[5:0]) - 64'd1;
          v = a & m;
          if (sgn && v[b[5:0] - 6'd1]) v = v | ~m;
        end
      end
      OP_ADD: begin
        if (trp && (sgn ? (a[63] == b[63] && ((a + b) ^ a) >> 63 != 0) : (~a < b)))
          okv = 1'b0;
        else v = a + b;
      end
      OP_SUB: begin
        if (trp && (sgn ? (a[63] != b[63] && ((a - b) ^ a) >> 63 != 0) : (a < b)))
          okv = 1'b0;
        else v = a - b;
      end
      OP_MPY: if (trp) okv = 1'b0; else v = a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          okv = 1'b0; dbz = 1'b1;
        end else if (sgn) begin
          na = a[63]; nb = b[63];
          ma = na ? -a : a; mb = nb ? -b : b;
          if (r.command == OP_DIV) begin
            if (trp && a == NEG_2P31 && b == '1) okv = 1'b0;
            else begin
              q = ma / mb;
              v = (na != nb) ? -q : q;
            end
          end else begin
            q = ma % mb;
            v = na ? -q : q;
          end
        end else v = (r.command == OP_DIV) ? a / b : a % b;
      end
      OP_AND: v = a & b;
      OP_IOR: v = a | b;
      OP_XOR: v = a ^ b;
      OP_SHL: begin
        if (r.narrow_32) v = sext_low32(a << b[4:0]);
        else v = a << b[5:0];
      end
      OP_SHR: begin
        sh = b[4:0];
        if (r.narrow_32)
          v = sgn ? 64'($signed(sext_low32(a)) >>> sh) : ({32'd0, a[31:0]} >> sh);
        else v = sgn ? 64'($signed(a) >>> b[5:0]) : (a >> b[5:0]);
      end
      OP_NOT: v = ~a;
      OP_LNOT: v = {63'd0, a == 64'd0};
      OP_SQR: if (trp) okv = 1'b0; else v = a * a;
      OP_NEG: if (trp && sgn && a == NEG_2P31) okv = 1'b0; else v = -a;
      OP_ABS: begin
        if (sgn && a == NEG_2P31) begin
          if (trp) okv = 1'b0; else v = a;
        end else if (sgn && a[63]) v = -a;
        else v = a;
      end
      OP_ODD: v = a & 64'd1;
      OP_GEQ: v = {63'd0, !signed_lt(a, b, sgn)};
      OP_GRT: v = {63'd0, signed_lt(b, a, sgn)};
      OP_LEQ: v = {63'd0, !signed_lt(b, a, sgn)};
      OP_LES: v = {63'd0, signed_lt(a, b, sgn)};
      OP_EQU: v = {63'd0, a == b};
      OP_NEQ: v = {63'd0, a != b};
      OP_MIN: v = signed_lt(b, a, sgn) ? b : a;
      OP_MAX: v = signed_lt(a, b, sgn) ? b : a;
      OP_DUP: v = a;
      default: okv = 1'b0;
    endcase
    if (!okv) v = '0;
    o.ok = okv; o.value = v; o.div_by_zero = dbz;
    return o;
  endfunction

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return NEG_2P31;
      3: return '1;
      4: return 64'(signed'($urandom_range(0, 80)) - 10);
      5: return {32'd0, $urandom()};
      6: return {{32{1'b1}}, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic add_cmd(logic [4:0] c, logic [63:0] a, logic [63:0] b,
                         logic s, logic n, logic t);
    req_t r;
    r.command = c; r.op_a = a; r.op_b = b;
    r.signed_mode = s; r.narrow_32 = n; r.trap_overflow = t;
    cmd_queue.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) fold_queue.push_back(fold_result(req));
      if (start && busy) begin
      end else if (cmd_queue.size() == 0 || hold_off) begin
        start <= 1'b0;
      end else if (burst_left == 0 && gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else begin
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
        req <= cmd_queue.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (fold_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", rsp);
      end else begin
        want = fold_queue.pop_front();
        if (rsp.ok !== want.ok || rsp.value !== want.value ||
            rsp.div_by_zero !== want.div_by_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected ok=%b value=%h dbz=%b, got ok=%b value=%h dbz=%b",
                     want.ok, want.value, want.div_by_zero,
                     rsp.ok, rsp.value, rsp.div_by_zero);
        end
      end
    end
  end

  initial begin
    logic [4:0] c;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // directed
    for (int i = 0; i < 32; i++) add_cmd(5'(i), 64'h8000_0000_0000_0001, 64'd3,
                                          i[0], i[1], i[2]);
    add_cmd(OP_DIV, 64'd5, 64'd0, 1'b1, 1'b0, 1'b0);
    add_cmd(OP_MOD, 64'd5, 64'd0, 1'b0, 1'b0, 1'b0);
    add_cmd(OP_DIV, 64'h8000_0000_0000_0000, '1, 1'b1, 1'b0, 1'b1);
    add_cmd(OP_MOD, 64'h8000_0000_0000_0000, '1, 1'b1, 1'b0, 1'b0);
    add_cmd(OP_DIV, NEG_2P31, '1, 1'b1, 1'b0, 1'b1);
    add_cmd(OP_NEG, NEG_2P31, 64'd0, 1'b1, 1'b0, 1'b1);
    add_cmd(OP_ABS, NEG_2P31, 64'd0, 1'b1, 1'b0, 1'b0);
    add_cmd(OP_ABS, NEG_2P31, 64'd0, 1'b1, 1'b0, 1'b1);
    add_cmd(OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 1'b1, 1'b0, 1'b1);
    add_cmd(OP_ADD, '1, 64'd1, 1'b0, 1'b0, 1'b1);
    add_cmd(OP_SUB, 64'd0, 64'd1, 1'b0, 1'b0, 1'b1);
    add_cmd(OP_CVTL, 64'h0000_0000_0000_00F0, 64'd8, 1'b1, 1'b0, 1'b0);
    add_cmd(OP_CVTL, 64'h1234, 64'd64, 1'b0, 1'b0, 1'b0);
    add_cmd(OP_CVTL, 64'h1234, 64'd0, 1'b1, 1'b0, 1'b0);
    add_cmd(OP_SHR, 64'h0000_0000_8000_0000, 64'd31, 1'b1, 1'b1, 1'b0);
    add_cmd(OP_SHL, 64'h1, 64'd63, 1'b0, 1'b0, 1'b0);
    wait (cmd_queue.size() == 0);
    hold_off = 1'b1;
    wait (fold_queue.size() == 0);
    hold_off = 1'b0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      c = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(26, 31)) : 5'($urandom_range(0, 25));
      add_cmd(c, pick_operand(),
              (c == OP_CVTL && $urandom_range(0, 1)) ? 64'($urandom_range(0, 70)) : pick_operand(),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if (i == RANDOM_BEATS / 2) begin
        wait (cmd_queue.size() == 0);
        hold_off = 1'b1;
        wait (fold_queue.size() == 0);
        hold_off = 1'b0;
      end
    end
    wait (cmd_queue.size() == 0 && !start);
    wait (fold_queue.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    stim_done = 1'b1;
    if (mismatches == 0) $display("constant_fold_alu_unit regression: pass");
    else $display("constant_fold_alu_unit regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    if (!stim_done) begin
      $display("constant_fold_alu_unit regression: fail");
      $finish;
    end
  end

endmodule
